### design/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the servo-bus frame receiver: receive phase
// encoding, framing bytes and the channel packing geometry.
// ----------------------------------------------------------------------------
package sfr_pkg;

	// Receive phase of the frame parser.
	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_FLAGS   = 2'd2,
		PH_END     = 2'd3
	} phase_t;

	// Framing bytes.
	localparam logic [7:0] START_BYTE = 8'h0F;
	localparam logic [7:0] END_BYTE_A = 8'h04;
	localparam logic [7:0] END_BYTE_B = 8'h14;
	localparam logic [7:0] END_BYTE_C = 8'h24;
	localparam logic [7:0] END_BYTE_D = 8'h34;

	// Flags bits 3:2; only the patterns 00 and 10 are accepted.
	localparam logic [7:0] FLAG_MASK  = 8'h0C;
	localparam logic [7:0] FLAG_OK_A  = 8'h00;
	localparam logic [7:0] FLAG_OK_B  = 8'h08;

	// Channel packing geometry.
	localparam int NUM_CHANNELS = 16;
	localparam int CHAN_BITS    = 11;
	localparam int CHAN_IDX_W   = 4;
	localparam int FRAME_BYTES  = 22;
	localparam int CNT_W        = 5;
	localparam int ACC_W        = CHAN_BITS + 7;
	localparam int NBITS_W      = 5;

	localparam logic [CHAN_IDX_W-1:0] LAST_CHAN = CHAN_IDX_W'(NUM_CHANNELS - 1);

endpackage

### design/sbus_frame_receiver.sv
// The parser takes one received byte per cycle while rx_stall is low; the unpacker reads the
// payload bytes back from the payload RAM one at a time, with one read in flight.
// An end byte waits (rx_stall) only while the previous frame's channels are still going out.
// Reset (arst_n low) returns the parser to hunting and empties the output; payload RAM is
// not cleared.
// ----------------------------------------------------------------------------
// sbus_frame_receiver
// Servo-bus frame decoder. Parses start byte, payload, flags and end byte,
// stores the payload in a two-bank RAM and unpacks 16 eleven-bit channels,
// least significant bit first, into one transaction per channel.
// ----------------------------------------------------------------------------
module sbus_frame_receiver #(
	parameter int PAYLOAD_BYTES = 22
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rx_valid,
	output logic                           rx_stall,
	input  logic [7:0]                     rx_byte,
	output logic                           ch_valid,
	input  logic                           ch_stall,
	output logic [sfr_pkg::CHAN_IDX_W-1:0] channel_index,
	output logic [sfr_pkg::CHAN_BITS-1:0]  channel_value,
	output logic                           last_channel
);
	import sfr_pkg::*;

	localparam int IDX_W     = $clog2(PAYLOAD_BYTES);
	localparam int MEM_DEPTH = 2 ** (IDX_W + 1);

	localparam logic [CNT_W-1:0]   PAYLOAD_CNT = CNT_W'(PAYLOAD_BYTES);
	localparam logic [CNT_W-1:0]   FRAME_CNT   = CNT_W'(FRAME_BYTES);
	localparam logic [NBITS_W-1:0] CHAN_NBITS  = NBITS_W'(CHAN_BITS);
	localparam logic [NBITS_W-1:0] BYTE_NBITS  = NBITS_W'(8);

	// Parser state.
	phase_t             phase_q;
	phase_t             phase_d;
	logic [CNT_W-1:0]   byte_count_q;
	logic [7:0]         flag_byte_q;
	logic               wr_bank_q;

	// Unpacker state.
	logic               busy_q;
	logic               rd_bank_q;
	logic [CNT_W-1:0]   rd_addr_q;
	logic               rd_pend_s1;
	logic               rd_zero_s1;
	logic [7:0]         rd_data_s1;
	logic [ACC_W-1:0]   acc_q;
	logic [NBITS_W-1:0] nbits_q;
	logic [CHAN_IDX_W-1:0] ch_q;

	// Output register.
	logic                  ch_valid_q;
	logic [CHAN_IDX_W-1:0] chan_index_q;
	logic [CHAN_BITS-1:0]  chan_value_q;
	logic                  last_q;

	logic [7:0] payload_mem_q [MEM_DEPTH];

	logic rx_fire;
	logic wr_en;
	logic flag_en;
	logic count_clr;
	logic end_ok;
	logic flags_ok;
	logic frame_ok;
	logic rd_issue;
	logic emit;
	logic [7:0] byte_in;
	logic [CNT_W-1:0] count_inc;

	// An end byte waits while the previous frame is still being unpacked.
	assign rx_stall  = (phase_q == PH_END) && busy_q;
	assign rx_fire   = rx_valid && !rx_stall;
	assign count_inc = byte_count_q + CNT_W'(1);

	// Frame check on the end byte and the stored flags.
	always_comb begin
		end_ok   = rx_byte inside {END_BYTE_A, END_BYTE_B, END_BYTE_C, END_BYTE_D};
		flags_ok = (flag_byte_q & FLAG_MASK) inside {FLAG_OK_A, FLAG_OK_B};
	end

	// Parser next state.
	always_comb begin
		phase_d = phase_q;
		if (rx_fire) begin
			case (phase_q)
				PH_HUNT: begin
					if (rx_byte == START_BYTE) begin
						phase_d = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					if (count_inc >= PAYLOAD_CNT) begin
						phase_d = PH_FLAGS;
					end
				end
				PH_FLAGS: phase_d = PH_END;
				PH_END:   phase_d = PH_HUNT;
				default:  phase_d = PH_HUNT;
			endcase
		end
	end

	// Parser outputs.
	always_comb begin
		wr_en     = 1'b0;
		flag_en   = 1'b0;
		count_clr = 1'b0;
		frame_ok  = 1'b0;
		if (rx_fire) begin
			case (phase_q)
				PH_HUNT:    count_clr = (rx_byte == START_BYTE);
				PH_PAYLOAD: wr_en = 1'b1;
				PH_FLAGS:   flag_en = 1'b1;
				PH_END:     frame_ok = end_ok && flags_ok;
				default:    wr_en = 1'b0;
			endcase
		end
	end

	// Parser registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			byte_count_q <= '0;
			flag_byte_q  <= '0;
			wr_bank_q    <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (count_clr) begin
				byte_count_q <= '0;
			end else if (wr_en) begin
				byte_count_q <= count_inc;
			end
			if (flag_en) begin
				flag_byte_q <= rx_byte;
			end
			if (frame_ok) begin
				wr_bank_q <= !wr_bank_q;
			end
		end
	end

	// Payload RAM: the parser fills one bank while the unpacker reads the other.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			payload_mem_q[{wr_bank_q, byte_count_q[IDX_W-1:0]}] <= rx_byte;
		end
		if (rd_issue) begin
			rd_data_s1 <= payload_mem_q[{rd_bank_q, rd_addr_q[IDX_W-1:0]}];
		end
	end

	// One read in flight; a byte is fetched only when fewer than one channel of
	// bits is held, so a returning byte and a channel emit never coincide.
	assign rd_issue = busy_q && !rd_pend_s1 && (nbits_q < CHAN_NBITS) &&
		(rd_addr_q < FRAME_CNT);
	assign emit     = busy_q && (nbits_q >= CHAN_NBITS) && (!ch_valid_q || !ch_stall);
	assign byte_in  = rd_zero_s1 ? 8'h00 : rd_data_s1;

	// Unpacker control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			rd_bank_q  <= 1'b0;
			rd_addr_q  <= '0;
			rd_pend_s1 <= 1'b0;
			rd_zero_s1 <= 1'b0;
			nbits_q    <= '0;
			ch_q       <= '0;
		end else if (frame_ok) begin
			busy_q     <= 1'b1;
			rd_bank_q  <= wr_bank_q;
			rd_addr_q  <= '0;
			rd_pend_s1 <= 1'b0;
			nbits_q    <= '0;
			ch_q       <= '0;
		end else begin
			rd_pend_s1 <= rd_issue;
			if (rd_issue) begin
				rd_zero_s1 <= (rd_addr_q >= PAYLOAD_CNT);
				rd_addr_q  <= rd_addr_q + CNT_W'(1);
			end
			if (rd_pend_s1) begin
				nbits_q <= nbits_q + BYTE_NBITS;
			end else if (emit) begin
				nbits_q <= nbits_q - CHAN_NBITS;
				ch_q    <= ch_q + CHAN_IDX_W'(1);
				if (ch_q == LAST_CHAN) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Bit accumulator, least significant bit first.
	always_ff @(posedge clk) begin
		if (frame_ok) begin
			acc_q <= '0;
		end else if (rd_pend_s1) begin
			acc_q <= acc_q | (ACC_W'(byte_in) << nbits_q);
		end else if (emit) begin
			acc_q <= acc_q >> CHAN_BITS;
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_valid_q <= 1'b0;
		end else if (emit) begin
			ch_valid_q <= 1'b1;
		end else if (!ch_stall) begin
			ch_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			chan_index_q <= ch_q;
			chan_value_q <= acc_q[CHAN_BITS-1:0];
			last_q       <= (ch_q == LAST_CHAN);
		end
	end

	assign ch_valid      = ch_valid_q;
	assign channel_index = chan_index_q;
	assign channel_value = chan_value_q;
	assign last_channel  = last_q;

	// The accumulator never holds more than one channel plus one byte.
	a_nbits_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nbits_q <= NBITS_W'(ACC_W))
		else $error("bit accumulator overflow");

	// A returning byte and a channel emit are never in the same cycle.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_pend_s1 && emit))
		else $error("read return collided with channel emit");

	// When a frame finishes, every byte was read and every bit used.
	a_frame_drained: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> (nbits_q == '0) && (rd_addr_q == FRAME_CNT) && !rd_pend_s1)
		else $error("frame finished with bits left over");

	// A new frame is started only when the unpacker is free.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		frame_ok |-> !busy_q)
		else $error("frame accepted while unpacking");

	// The marked transaction carries the highest channel number.
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		ch_valid && last_channel |-> channel_index == LAST_CHAN)
		else $error("last channel mark on wrong channel");

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the servo-bus frame receiver. A table of directed
// frames covers the framing rules and extreme payloads. Random frames, mostly
// well formed, with random content follow, mixed with noise and cut-off frames.
// A byte-level decoder kept in the bench predicts every channel transaction,
// and the bench checks each one field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sfr_pkg::*;

	localparam int PAYLOAD_LEN = 22;
	localparam int IDLE_LIMIT  = 4000;
	localparam int RANDOM_BYTES = 200;

	// How the expected channels of a directed frame are obtained.
	typedef enum logic [1:0] {
		CHK_MODEL = 2'd0,
		CHK_NONE  = 2'd1,
		CHK_ALL   = 2'd2
	} frame_check_t;

	typedef struct packed {
		logic         has_lead;
		logic [7:0]   lead;
		logic         ramp;
		logic [7:0]   fill;
		logic [7:0]   flags;
		logic [7:0]   end_byte;
		frame_check_t check;
		logic [10:0]  value;
	} frame_row_t;

	typedef struct packed {
		logic [CHAN_IDX_W-1:0] index;
		logic [CHAN_BITS-1:0]  value;
		logic                  last;
	} chan_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  rx_valid = 1'b0;
	logic                  rx_stall;
	logic [7:0]            rx_byte = 8'h00;
	logic                  ch_valid;
	logic                  ch_stall = 1'b0;
	logic [CHAN_IDX_W-1:0] channel_index;
	logic [CHAN_BITS-1:0]  channel_value;
	logic                  last_channel;

	// Directed frames: an optional lead byte while hunting, payload, flags and end byte.
	frame_row_t directed_frames [0:9] = '{
		'{1'b1, 8'hFF, 1'b0, 8'hFF, 8'h00, END_BYTE_A, CHK_ALL,   11'h7FF},
		'{1'b0, 8'h00, 1'b0, 8'h00, 8'h08, END_BYTE_B, CHK_ALL,   11'h000},
		'{1'b1, 8'h00, 1'b1, 8'h00, 8'hF3, END_BYTE_C, CHK_MODEL, 11'h000},
		'{1'b0, 8'h00, 1'b0, 8'hAA, 8'h04, END_BYTE_D, CHK_NONE,  11'h000},
		'{1'b0, 8'h00, 1'b0, 8'h0F, 8'h0C, END_BYTE_A, CHK_NONE,  11'h000},
		'{1'b1, 8'h0E, 1'b0, 8'h55, 8'hFB, START_BYTE, CHK_NONE,  11'h000},
		'{1'b0, 8'h00, 1'b0, 8'h0F, 8'h08, END_BYTE_D, CHK_MODEL, 11'h000},
		'{1'b0, 8'h00, 1'b0, 8'hFF, 8'h00, 8'h05,      CHK_NONE,  11'h000},
		'{1'b1, 8'hF0, 1'b0, 8'hFF, 8'h00, 8'h44,      CHK_NONE,  11'h000},
		'{1'b0, 8'h00, 1'b0, 8'h5A, 8'hFB, END_BYTE_B, CHK_MODEL, 11'h000}
	};

	// Decoder state kept by the bench.
	phase_t       rx_phase = PH_HUNT;
	logic [4:0]   rx_count = 5'd0;
	logic [7:0]   frame_store [0:FRAME_BYTES-1];
	logic [7:0]   flags_seen = 8'h00;
	frame_check_t row_check = CHK_MODEL;
	logic [10:0]  row_value = 11'h000;
	chan_result_t channels_due [$];

	int  err_count = 0;
	int  quiet_cycles = 0;
	bit  send_eager = 1'b0;
	bit  take_eager = 1'b0;
	int  take_wait = 0;
	int  hold_left = 0;
	int  taken_count = 0;

	sbus_frame_receiver #(
		.PAYLOAD_BYTES(PAYLOAD_LEN)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_valid     (rx_valid),
		.rx_stall     (rx_stall),
		.rx_byte      (rx_byte),
		.ch_valid     (ch_valid),
		.ch_stall     (ch_stall),
		.channel_index(channel_index),
		.channel_value(channel_value),
		.last_channel (last_channel)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Advance the decoder by one received byte and queue the channels of an
	// accepted frame.
	task automatic decode_rx_byte(input logic [7:0] b);
		logic [FRAME_BYTES*8-1:0] bits;
		chan_result_t             r;
		logic [7:0]               fm;
		case (rx_phase)
			PH_HUNT: begin
				if (b == START_BYTE) begin
					rx_count = 5'd0;
					rx_phase = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				if (rx_count < FRAME_BYTES)
					frame_store[rx_count] = b;
				rx_count = rx_count + 5'd1;
				if (rx_count >= PAYLOAD_LEN)
					rx_phase = PH_FLAGS;
			end
			PH_FLAGS: begin
				flags_seen = b;
				rx_phase = PH_END;
			end
			default: begin
				rx_phase = PH_HUNT;
				fm = flags_seen & FLAG_MASK;
				if ((b == END_BYTE_A || b == END_BYTE_B || b == END_BYTE_C ||
						b == END_BYTE_D) && (fm == FLAG_OK_A || fm == FLAG_OK_B) &&
						row_check != CHK_NONE) begin
					// Payload bytes past the configured length read as zero.
					for (int i = 0; i < FRAME_BYTES; i++)
						bits[i*8 +: 8] = (i < PAYLOAD_LEN) ? frame_store[i] : 8'h00;
					for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
						r.index = CHAN_IDX_W'(ch);
						r.value = (row_check == CHK_ALL) ? row_value :
							bits[ch*CHAN_BITS +: CHAN_BITS];
						r.last  = (r.index == LAST_CHAN);
						channels_due.push_back(r);
					end
				end
			end
		endcase
	endtask

	// Offer one byte after a random gap (none when send_eager is set) and hold it until it is taken.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = send_eager ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (rx_stall !== 1'b0);
		@(negedge clk);
	endtask

	// Receiver side: random stall before each channel transaction, plus one
	// long hold-off so that the input side backs up.
	always @(negedge clk) begin
		if (!arst_n) begin
			ch_stall <= 1'b0;
		end else if (hold_left > 0) begin
			ch_stall <= 1'b1;
			hold_left--;
		end else if (take_wait > 0) begin
			ch_stall <= 1'b1;
			take_wait--;
		end else begin
			ch_stall <= 1'b0;
			if (ch_valid === 1'b1) begin
				taken_count++;
				if (taken_count % 32 == 0)
					take_eager = ($urandom_range(0, 2) == 0);
				take_wait = take_eager ? 0 : $urandom_range(0, 11);
				if (taken_count == 40)
					hold_left = 600;
			end
		end
	end

	// Feed accepted bytes to the decoder and check every channel transaction.
	always @(posedge clk) begin
		chan_result_t want;
		if (arst_n) begin
			if (rx_valid && rx_stall === 1'b0)
				decode_rx_byte(rx_byte);
			if (ch_valid === 1'b1 && !ch_stall) begin
				if (channels_due.size() == 0) begin
					$display("%0t: unexpected channel transaction: expected none, actual index %0d value %0d last %0d",
						$time, channel_index, channel_value, last_channel);
					err_count++;
				end else begin
					want = channels_due.pop_front();
					if (channel_index !== want.index) begin
						$display("%0t: channel_index expected %0d actual %0d",
							$time, want.index, channel_index);
						err_count++;
					end
					if (channel_value !== want.value) begin
						$display("%0t: channel_value expected %0d actual %0d",
							$time, want.value, channel_value);
						err_count++;
					end
					if (last_channel !== want.last) begin
						$display("%0t: last_channel expected %0d actual %0d",
							$time, want.last, last_channel);
						err_count++;
					end
				end
			end
		end
	end

	// Watchdog on cycles in which neither side moves a transaction.
	always @(posedge clk) begin
		if ((rx_valid && rx_stall === 1'b0) || (ch_valid === 1'b1 && !ch_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
			$display("sbus_frame_receiver regression: fail");
			$finish;
		end
	end

	initial begin
		frame_row_t row;
		logic [7:0] b;
		logic [7:0] f;
		int         frame_bytes;
		int         style;
		int         n;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed frames.
		foreach (directed_frames[i]) begin
			row = directed_frames[i];
			row_check = row.check;
			row_value = row.value;
			send_eager = ($urandom_range(0, 3) == 0);
			if (row.has_lead)
				send_byte(row.lead);
			send_byte(START_BYTE);
			for (int k = 0; k < PAYLOAD_LEN; k++)
				send_byte(row.ramp ? 8'(k * 37 + 5) : row.fill);
			send_byte(row.flags);
			send_byte(row.end_byte);
		end
		row_check = CHK_MODEL;

		// Random frames: mostly well formed, some cut short, noise in between.
		frame_bytes = 0;
		while (frame_bytes < RANDOM_BYTES) begin
			send_eager = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(0, 2))
				send_byte(8'($urandom));
			if ($urandom_range(0, 9) < 8) begin
				style = $urandom_range(0, 7);
				send_byte(START_BYTE);
				for (int k = 0; k < PAYLOAD_LEN; k++) begin
					case (style)
						0:       b = 8'hFF;
						1:       b = 8'h00;
						default: b = 8'($urandom);
					endcase
					send_byte(b);
				end
				// Keep flags bit 2 clear most of the time so the frame passes.
				f = 8'($urandom);
				if ($urandom_range(0, 6) != 0)
					f[2] = 1'b0;
				send_byte(f);
				if ($urandom_range(0, 6) != 0) begin
					case ($urandom_range(0, 3))
						0:       b = END_BYTE_A;
						1:       b = END_BYTE_B;
						2:       b = END_BYTE_C;
						default: b = END_BYTE_D;
					endcase
				end else begin
					b = 8'($urandom);
				end
				send_byte(b);
				frame_bytes += PAYLOAD_LEN + 3;
			end else begin
				n = $urandom_range(1, 30);
				send_byte(START_BYTE);
				repeat (n)
					send_byte(8'($urandom));
				frame_bytes += n + 1;
			end
		end
		rx_valid <= 1'b0;

		// Drain the channels still due, then watch for stray transactions.
		while (channels_due.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		if (err_count == 0 && channels_due.size() == 0)
			$display("sbus_frame_receiver regression: pass");
		else
			$display("sbus_frame_receiver regression: fail");
		$finish;
	end

endmodule

### files.f
design/sfr_pkg.sv
design/sbus_frame_receiver.sv
tb/sv/tb_top.sv
